/* hdl/lpfq_pkg.sv */
// ----------------------------------------------------------------------------
// lpfq_pkg
// Types and constants shared by the pause flow control queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfq_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] MAX_BYTES_RST = 24'd1048576;
	localparam logic [CFG_DATA_W-1:0] HIGH_THR_RST  = 24'd1048576;
	localparam logic [CFG_DATA_W-1:0] LOW_THR_RST   = 24'd0;

	localparam logic [24:0] BYTES_MAX       = 25'h1FFFFFF;
	localparam logic [15:0] PAUSE_ON_QUANTA = 16'd1000;
	localparam logic [15:0] PAUSE_OFF_QUANTA = 16'd0;

	typedef enum logic [1:0] {
		REQ_PAUSE  = 2'd0,
		REQ_ARRIVE = 2'd1,
		REQ_DONE   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_PENDING = 2'd1,
		ST_PAUSED  = 2'd2
	} send_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] pause_quanta;
		logic [13:0] pkt_size;
		logic [15:0] pkt_tag;
	} in_item_t;

	typedef struct packed {
		logic        start_service;
		logic        depart_valid;
		logic [13:0] depart_size;
		logic [15:0] depart_tag;
		logic        pause_emit;
		logic [15:0] pause_out_quanta;
		logic        over_limit;
		logic        dropped;
		logic        error_flag;
		logic [24:0] occupancy;
		logic [1:0]  send_state_out;
	} out_item_t;

	typedef struct packed {
		logic [13:0] size;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic rd;
		logic push;
		logic pop;
	} fifo_cmd_t;

	typedef struct packed {
		logic empty;
		logic one;
		logic full;
	} fifo_status_t;

endpackage

`default_nettype wire

/* hdl/lpfq_if.sv */
// ----------------------------------------------------------------------------
// lpfq_in_if / lpfq_out_if
// Valid/ready channels for queue events and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfq_in_if;
	import lpfq_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface lpfq_out_if;
	import lpfq_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

/* hdl/lpfq_fifo.sv */
// ----------------------------------------------------------------------------
// lpfq_fifo
// Packet size/tag store: one synchronous memory with head and tail
// pointers, a fill count and a registered read of the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfq_fifo #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpfq_pkg::fifo_cmd_t    cmd,
	input  lpfq_pkg::entry_t       wr_data,
	output lpfq_pkg::entry_t       rd_data,
	output lpfq_pkg::fifo_status_t status
);
	import lpfq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	entry_t        mem [DEPTH];
	entry_t        rd_data_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + AW'(1);
			end
			if (cmd.pop) begin
				head_q <= (head_q == LAST) ? '0 : head_q + AW'(1);
			end
			if (cmd.push && !cmd.pop) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop && !cmd.push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data      = rd_data_q;
	assign status.empty = (count_q == '0);
	assign status.one   = (count_q == CW'(1));
	assign status.full  = (count_q == CW'(DEPTH));

endmodule

`default_nettype wire

/* hdl/lossless_pause_flow_queue_unit.sv */
// Egress port queue with link-level pause flow control. Each input transaction
// is a received pause frame, a packet arrival or a transmission complete, and
// gives exactly one result transaction. In the accept cycle the head entry of
// the size/tag memory is read into its registered read port; once the output
// register is free, the registered read data, byte count and send state are
// updated and the result is loaded into the output register. A new transaction
// is taken while a result still waits on the output. The size/tag store needs
// no clearing after reset.
// ----------------------------------------------------------------------------
// lossless_pause_flow_queue_unit
// Top level: config registers, event commit stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lossless_pause_flow_queue_unit #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lpfq_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [lpfq_pkg::CFG_DATA_W-1:0]  cfg_data,
	lpfq_in_if.sink                          in_ch,
	lpfq_out_if.source                       out_ch
);
	import lpfq_pkg::*;

	logic [CFG_DATA_W-1:0] max_bytes_q;
	logic [CFG_DATA_W-1:0] high_thr_q;
	logic [CFG_DATA_W-1:0] low_thr_q;

	logic [24:0]  queued_q;
	send_state_t  send_q;
	logic         up_paused_q;
	logic         in_flight_q;

	logic         s1_valid_q;
	in_item_t     item_s1;
	logic         out_valid_q;
	out_item_t    out_q;

	logic         accept;
	logic         commit;

	fifo_cmd_t    fcmd;
	fifo_status_t fstat;
	entry_t       wr_entry;
	entry_t       head_entry;

	logic [25:0]  sum;
	logic [24:0]  q_n;
	send_state_t  send_n;
	logic         up_n;
	logic         fl_n;
	logic         push_c;
	logic         pop_c;
	logic         nonempty_n;
	out_item_t    res;

	assign in_ch.ready = !s1_valid_q;
	assign accept      = in_ch.valid && !s1_valid_q;
	assign commit      = s1_valid_q && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
			high_thr_q  <= HIGH_THR_RST;
			low_thr_q   <= LOW_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				CFG_HIGH_THR:  high_thr_q  <= cfg_data;
				CFG_LOW_THR:   low_thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wr_entry.size = item_s1.pkt_size;
	assign wr_entry.tag  = item_s1.pkt_tag;
	assign fcmd.rd       = accept;
	assign fcmd.push     = commit && push_c;
	assign fcmd.pop      = commit && pop_c;

	lpfq_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (fcmd),
		.wr_data (wr_entry),
		.rd_data (head_entry),
		.status  (fstat)
	);

	always_comb begin
		sum    = {1'b0, queued_q} + 26'(item_s1.pkt_size);
		q_n    = queued_q;
		send_n = send_q;
		up_n   = up_paused_q;
		fl_n   = in_flight_q;
		push_c = 1'b0;
		pop_c  = 1'b0;
		res    = '0;
		unique case (item_s1.req_type)
			REQ_PAUSE: begin
				if (item_s1.pause_quanta != '0) begin
					send_n = in_flight_q ? ST_PENDING : ST_PAUSED;
				end else begin
					send_n = ST_READY;
				end
			end
			REQ_ARRIVE: begin
				if (fstat.full) begin
					res.dropped = 1'b1;
				end else begin
					push_c = 1'b1;
					q_n    = (sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : sum[24:0];
					if (q_n > {1'b0, high_thr_q} && !up_paused_q) begin
						up_n                 = 1'b1;
						res.pause_emit       = 1'b1;
						res.pause_out_quanta = PAUSE_ON_QUANTA;
					end
					res.over_limit = (q_n > {1'b0, max_bytes_q});
				end
			end
			REQ_DONE: begin
				if (!in_flight_q || fstat.empty) begin
					res.error_flag = 1'b1;
				end else begin
					pop_c            = 1'b1;
					res.depart_valid = 1'b1;
					res.depart_size  = head_entry.size;
					res.depart_tag   = head_entry.tag;
					q_n = (queued_q > 25'(head_entry.size)) ?
						queued_q - 25'(head_entry.size) : '0;
					fl_n = 1'b0;
					if (send_q == ST_PENDING) begin
						send_n = ST_PAUSED;
					end
					if (q_n < {1'b0, low_thr_q} && up_paused_q) begin
						up_n                 = 1'b0;
						res.pause_emit       = 1'b1;
						res.pause_out_quanta = PAUSE_OFF_QUANTA;
					end
				end
			end
			default: ;
		endcase
		nonempty_n = push_c ? 1'b1 : (pop_c ? !fstat.one : !fstat.empty);
		if (send_n == ST_READY && !fl_n && nonempty_n) begin
			fl_n              = 1'b1;
			res.start_service = 1'b1;
		end
		res.occupancy      = q_n;
		res.send_state_out = send_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q    <= '0;
			send_q      <= ST_READY;
			up_paused_q <= 1'b0;
			in_flight_q <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				queued_q    <= q_n;
				send_q      <= send_n;
				up_paused_q <= up_n;
				in_flight_q <= fl_n;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_ch.item;
		end
		if (commit) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_q;

	a_commit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("committed transaction did not reach the output register");

	a_pending_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		send_q == ST_PENDING |-> in_flight_q)
		else $error("pause pending without a packet in flight");

	a_flight_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q |-> !fstat.empty)
		else $error("packet in flight with an empty queue");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.empty |-> queued_q == '0)
		else $error("byte count nonzero with an empty queue");

endmodule

`default_nettype wire

/* tb/tb_lossless_pause_flow_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_lossless_pause_flow_queue_unit
// Self-checking bench for the pause flow control port queue. A directed table
// covers reset state, field extremes, pause/resume while idle and in flight,
// spurious completions and the unused request code. A fill burst overflows
// the packet FIFO. Randomized event streams then run under several threshold
// settings with random idling on both channels. Every result transaction is
// compared field by field with the table's expected row or an in-bench model.
// ----------------------------------------------------------------------------

module tb_lossless_pause_flow_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfq_pkg::*;

	localparam int QUEUE_DEPTH    = 64;
	localparam int PHASES         = 8;
	localparam int PHASE_EVENTS   = 140;
	localparam int BURST_ARRIVALS = QUEUE_DEPTH + 6;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT       = 36;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 18;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{REQ_UNUSED, 16'hFFFF, 14'h3FFF, 16'hFFFF}, 1'b1,
			'{1'b0, 1'b0, 14'd0, 16'd0, 1'b0, PAUSE_OFF_QUANTA, 1'b0, 1'b0, 1'b0,
				25'd0, ST_READY}},
		'{'{REQ_DONE, 16'h0000, 14'h0000, 16'h0000}, 1'b1,
			'{1'b0, 1'b0, 14'd0, 16'd0, 1'b0, PAUSE_OFF_QUANTA, 1'b0, 1'b0, 1'b1,
				25'd0, ST_READY}},
		'{'{REQ_PAUSE, 16'hFFFF, 14'h0000, 16'h0000}, 1'b1,
			'{1'b0, 1'b0, 14'd0, 16'd0, 1'b0, PAUSE_OFF_QUANTA, 1'b0, 1'b0, 1'b0,
				25'd0, ST_PAUSED}},
		'{'{REQ_ARRIVE, 16'h0000, 14'h3FFF, 16'hFFFF}, 1'b1,
			'{1'b0, 1'b0, 14'd0, 16'd0, 1'b1, PAUSE_ON_QUANTA, 1'b0, 1'b0, 1'b0,
				25'd16383, ST_PAUSED}},
		'{'{REQ_ARRIVE, 16'hFFFF, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_ARRIVE, 16'h0000, 14'd8000, 16'h1234}, 1'b0, '0},
		'{'{REQ_UNUSED, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_PAUSE, 16'h0000, 14'h3FFF, 16'hFFFF}, 1'b0, '0},
		'{'{REQ_PAUSE, 16'h0001, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_PAUSE, 16'hFFFF, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_ARRIVE, 16'h0000, 14'd100, 16'hAAAA}, 1'b0, '0},
		'{'{REQ_DONE, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_PAUSE, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_DONE, 16'hFFFF, 14'h3FFF, 16'hFFFF}, 1'b0, '0},
		'{'{REQ_PAUSE, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_DONE, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_DONE, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0},
		'{'{REQ_DONE, 16'h0000, 14'h0000, 16'h0000}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	lpfq_in_if  in_ch ();
	lpfq_out_if out_ch ();

	lossless_pause_flow_queue_unit #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// queue model state
	logic [CFG_DATA_W-1:0] lim_max  = MAX_BYTES_RST;
	logic [CFG_DATA_W-1:0] lim_high = HIGH_THR_RST;
	logic [CFG_DATA_W-1:0] lim_low  = LOW_THR_RST;
	logic [24:0]  held_bytes   = '0;
	send_state_t  link_state   = ST_READY;
	logic         upstream_off = 1'b0;
	logic         busy         = 1'b0;
	entry_t       pkt_q[$];

	out_item_t result_q[$];
	int  mismatches   = 0;
	int  results_seen = 0;
	int  hold_at      = -1;
	int  stall_cycles = 0;
	bit  no_idle      = 1'b0;

	function automatic out_item_t predict_event(input in_item_t ev);
		out_item_t   r;
		entry_t      head;
		logic [25:0] sum;
		r = '0;
		if (ev.req_type == REQ_PAUSE) begin
			if (ev.pause_quanta != 16'd0)
				link_state = busy ? ST_PENDING : ST_PAUSED;
			else
				link_state = ST_READY;
		end else if (ev.req_type == REQ_ARRIVE) begin
			if (pkt_q.size() >= QUEUE_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				pkt_q.push_back('{ev.pkt_size, ev.pkt_tag});
				sum = {1'b0, held_bytes} + 26'(ev.pkt_size);
				held_bytes = (sum > 26'(BYTES_MAX)) ? BYTES_MAX : sum[24:0];
				if (held_bytes > 25'(lim_high) && !upstream_off) begin
					upstream_off       = 1'b1;
					r.pause_emit       = 1'b1;
					r.pause_out_quanta = PAUSE_ON_QUANTA;
				end
				if (held_bytes > 25'(lim_max))
					r.over_limit = 1'b1;
			end
		end else if (ev.req_type == REQ_DONE) begin
			if (!busy || pkt_q.size() == 0) begin
				r.error_flag = 1'b1;
			end else begin
				head = pkt_q.pop_front();
				r.depart_valid = 1'b1;
				r.depart_size  = head.size;
				r.depart_tag   = head.tag;
				held_bytes = (held_bytes > 25'(head.size)) ?
					held_bytes - 25'(head.size) : '0;
				busy = 1'b0;
				if (link_state == ST_PENDING)
					link_state = ST_PAUSED;
				if (held_bytes < 25'(lim_low) && upstream_off) begin
					upstream_off       = 1'b0;
					r.pause_emit       = 1'b1;
					r.pause_out_quanta = PAUSE_OFF_QUANTA;
				end
			end
		end
		if (link_state == ST_READY && !busy && pkt_q.size() > 0) begin
			busy            = 1'b1;
			r.start_service = 1'b1;
		end
		r.occupancy      = held_bytes;
		r.send_state_out = link_state;
		return r;
	endfunction

	function automatic in_item_t random_event();
		in_item_t ev;
		int       pick;
		ev.pause_quanta = 16'($urandom);
		ev.pkt_size     = 14'($urandom);
		ev.pkt_tag      = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 42) begin
			ev.req_type = REQ_ARRIVE;
		end else if (pick < 80) begin
			ev.req_type = REQ_DONE;
		end else if (pick < 88) begin
			ev.req_type     = REQ_PAUSE;
			ev.pause_quanta = 16'd0;
		end else if (pick < 95) begin
			ev.req_type = REQ_PAUSE;
			if (ev.pause_quanta == 16'd0)
				ev.pause_quanta = 16'd1;
		end else begin
			ev.req_type = REQ_UNUSED;
		end
		return ev;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		results_seen++;
		if (result_q.size() == 0) begin
			$display("%0t: unexpected result transaction 0x%0h", $time, got);
			mismatches++;
		end else begin
			want = result_q.pop_front();
			check_field("start_service", 32'(want.start_service), 32'(got.start_service));
			check_field("depart_valid", 32'(want.depart_valid), 32'(got.depart_valid));
			check_field("depart_size", 32'(want.depart_size), 32'(got.depart_size));
			check_field("depart_tag", 32'(want.depart_tag), 32'(got.depart_tag));
			check_field("pause_emit", 32'(want.pause_emit), 32'(got.pause_emit));
			check_field("pause_out_quanta", 32'(want.pause_out_quanta),
				32'(got.pause_out_quanta));
			check_field("over_limit", 32'(want.over_limit), 32'(got.over_limit));
			check_field("dropped", 32'(want.dropped), 32'(got.dropped));
			check_field("error_flag", 32'(want.error_flag), 32'(got.error_flag));
			check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
			check_field("send_state_out", 32'(want.send_state_out),
				32'(got.send_state_out));
		end
	endtask

	task automatic send_event(input in_item_t ev, input logic typed, input out_item_t want);
		out_item_t pred;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.item  <= ev;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred = predict_event(ev);
		result_q.push_back(typed ? want : pred);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_thresholds(input logic [CFG_DATA_W-1:0] mb, hb, lb);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_MAX_BYTES;
		cfg_data <= mb;
		@(posedge clk);
		cfg_idx  <= CFG_HIGH_THR;
		cfg_data <= hb;
		@(posedge clk);
		cfg_idx  <= CFG_LOW_THR;
		cfg_data <= lb;
		@(posedge clk);
		cfg_we   <= 1'b0;
		lim_max  = mb;
		lim_high = hb;
		lim_low  = lb;
	endtask

	initial begin : result_sink
		int hold_left;
		hold_left    = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				check_result(out_ch.item);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (results_seen == hold_at) begin
				hold_at      = -1;
				hold_left    = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[lossless_pause_flow_queue_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		in_item_t              ev;
		logic [CFG_DATA_W-1:0] mb, hb, lb;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_data    = '0;
		in_ch.valid = 1'b0;
		in_ch.item  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_thresholds(24'd20000, 24'd10000, 24'd5000);
		foreach (DIRECTED[i])
			send_event(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
		wait_drain();

		// fill the packet FIFO past its depth while sending is paused
		load_thresholds(24'd500000, 24'd300000, 24'd100000);
		send_event('{REQ_PAUSE, 16'hFFFF, 14'($urandom), 16'($urandom)}, 1'b0, '0);
		repeat (BURST_ARRIVALS)
			send_event('{REQ_ARRIVE, 16'($urandom), 14'($urandom), 16'($urandom)}, 1'b0, '0);
		send_event('{REQ_PAUSE, 16'h0000, 14'($urandom), 16'($urandom)}, 1'b0, '0);
		repeat (BURST_ARRIVALS)
			send_event('{REQ_DONE, 16'($urandom), 14'($urandom), 16'($urandom)}, 1'b0, '0);
		wait_drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin mb = MAX_BYTES_RST; hb = HIGH_THR_RST; lb = LOW_THR_RST; end
				1: begin mb = '0; hb = '0; lb = '0; end
				2: begin mb = '1; hb = '1; lb = '1; end
				3: begin mb = '0; hb = '1; lb = '0; end
				default: begin
					mb = 24'($urandom_range(0, 600000));
					hb = 24'($urandom_range(0, 400000));
					lb = 24'($urandom_range(0, 32'(hb)));
				end
			endcase
			load_thresholds(mb, hb, lb);
			no_idle = (phase == 4);
			if (phase == 5)
				hold_at = results_seen + 30;
			repeat (PHASE_EVENTS) begin
				ev = random_event();
				send_event(ev, 1'b0, '0);
			end
			wait_drain();
			no_idle = 1'b0;
		end

		if (result_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, result_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[lossless_pause_flow_queue_unit] OK");
		else
			$display("[lossless_pause_flow_queue_unit] ERROR");
		$finish;
	end

endmodule
